@@ rtl/rcf_pkg.sv @@
// ----------------------------------------------------------------------------
// rcf_pkg
// Types, constants and the weight table of the RGB color filter pipeline.
// ----------------------------------------------------------------------------
package rcf_pkg;

   localparam int CHAN_W      = 8;
   localparam int MODE_W      = 3;
   localparam int WEIGHT_W    = 11;
   localparam int PROD_W      = 19;
   localparam int SUM_W       = 19;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 29;
   localparam int FULL_W      = SUM_W + RECIP_W;
   localparam int QUOT_W      = 9;
   localparam int NUM_CHAN    = 3;

   // ceil(2^29 / 1000): exact floor(x / 1000) for x < 2^19
   localparam logic [RECIP_W-1:0] RECIP_1000 = 20'd536871;
   localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'hFF;
   localparam logic [CHAN_W-1:0]  POP_THRESH = 8'd127;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE   = 3'd0,
      MODE_SEPIA  = 3'd1,
      MODE_COOL   = 3'd2,
      MODE_HEAT   = 3'd3,
      MODE_GRAY   = 3'd4,
      MODE_DARKEN = 3'd5,
      MODE_POP    = 3'd6
   } mode_type;

   // [output channel][input channel], channel 0 red, 1 green, 2 blue
   typedef logic [NUM_CHAN-1:0][NUM_CHAN-1:0][WEIGHT_W-1:0] weight_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][CHAN_W-1:0] color;
      logic [CHAN_W-1:0]               alpha;
   } pixel_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][NUM_CHAN-1:0][PROD_W-1:0] prod;
      logic                                          pop;
      logic [NUM_CHAN-1:0]                           pop_bits;
      logic [CHAN_W-1:0]                             alpha;
   } prod_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][SUM_W-1:0] sum;
      logic                           pop;
      logic [NUM_CHAN-1:0]            pop_bits;
      logic [CHAN_W-1:0]              alpha;
   } sum_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][FULL_W-1:0] full;
      logic                            pop;
      logic [NUM_CHAN-1:0]             pop_bits;
      logic [CHAN_W-1:0]               alpha;
   } full_type;

   // every mode but pop art is a weighted sum over 1000
   function automatic weight_type get_weights(input logic [MODE_W-1:0] mode);
      weight_type w;
      w = '0;
      case (mode)
         MODE_SEPIA: begin
            w[0] = {11'd189, 11'd769, 11'd393};
            w[1] = {11'd168, 11'd686, 11'd349};
            w[2] = {11'd131, 11'd534, 11'd272};
         end
         MODE_COOL: begin
            w[0][0] = 11'd800;
            w[1][1] = 11'd1000;
            w[2][2] = 11'd1200;
         end
         MODE_HEAT: begin
            w[0][0] = 11'd1300;
            w[1][1] = 11'd900;
            w[2][2] = 11'd700;
         end
         MODE_GRAY: begin
            w[0] = {11'd114, 11'd587, 11'd299};
            w[1] = {11'd114, 11'd587, 11'd299};
            w[2] = {11'd114, 11'd587, 11'd299};
         end
         MODE_DARKEN: begin
            w[0][0] = 11'd850;
            w[1][1] = 11'd850;
            w[2][2] = 11'd850;
         end
         default: begin
            w[0][0] = 11'd1000;
            w[1][1] = 11'd1000;
            w[2][2] = 11'd1000;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/rgb_color_filter.sv @@
// Path: a request passes four register stages (product, sum, reciprocal product, output).
// Throughput: one request per cycle; the stages hold under backpressure.
// Cost per pixel is set by the weight multipliers and the divide-by-1000
// reciprocal multiplier, each with a register stage of its own.
// Reset: synchronous, active high; clears stage valids and sets filter mode to none.
// ----------------------------------------------------------------------------
// rgb_color_filter
// RGBA pixel recoloring pipeline with a configurable filter mode.
// ----------------------------------------------------------------------------
module rgb_color_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [rcf_pkg::MODE_W-1:0] csr_filter_mode,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rcf_pkg::CHAN_W-1:0] req_red_in,
   input  logic [rcf_pkg::CHAN_W-1:0] req_green_in,
   input  logic [rcf_pkg::CHAN_W-1:0] req_blue_in,
   input  logic [rcf_pkg::CHAN_W-1:0] req_alpha_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rcf_pkg::CHAN_W-1:0] rsp_red_out,
   output logic [rcf_pkg::CHAN_W-1:0] rsp_green_out,
   output logic [rcf_pkg::CHAN_W-1:0] rsp_blue_out,
   output logic [rcf_pkg::CHAN_W-1:0] rsp_alpha_out
);
   import rcf_pkg::*;

   logic [MODE_W-1:0] filter_mode_ff;
   pixel_type         req_pixel;
   pixel_type         rsp_pixel;
   logic              prod_valid;
   logic              prod_ready;
   prod_type          prod_data;
   logic              sum_valid;
   logic              sum_ready;
   sum_type           sum_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= MODE_NONE;
      end else if (csr_write) begin
         filter_mode_ff <= csr_filter_mode;
      end
   end

   assign req_pixel.color[0] = req_red_in;
   assign req_pixel.color[1] = req_green_in;
   assign req_pixel.color[2] = req_blue_in;
   assign req_pixel.alpha    = req_alpha_in;

   rcf_product u_product (
      .clock     (clock),
      .reset     (reset),
      .mode      (filter_mode_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_pixel),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   rcf_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   rcf_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_pixel)
   );

   assign rsp_red_out   = rsp_pixel.color[0];
   assign rsp_green_out = rsp_pixel.color[1];
   assign rsp_blue_out  = rsp_pixel.color[2];
   assign rsp_alpha_out = rsp_pixel.alpha;

endmodule

@@ rtl/rcf_product.sv @@
// ----------------------------------------------------------------------------
// rcf_product
// First stage: mode weights times channels, pop art threshold bits.
// ----------------------------------------------------------------------------
module rcf_product (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rcf_pkg::MODE_W-1:0]    mode,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rcf_pkg::pixel_type            in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rcf_pkg::prod_type             out_data
);
   import rcf_pkg::*;

   logic       valid_ff;
   prod_type   data_ff;
   prod_type   data_in;
   weight_type weights;

   assign weights  = get_weights(mode);
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in       = '0;
      data_in.alpha = in_data.alpha;
      data_in.pop   = (mode == MODE_POP);
      for (int o = 0; o < NUM_CHAN; o++) begin
         data_in.pop_bits[o] = (in_data.color[o] > POP_THRESH);
         for (int i = 0; i < NUM_CHAN; i++) begin
            data_in.prod[o][i] = PROD_W'(in_data.color[i]) * PROD_W'(weights[o][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/rcf_sum.sv @@
// ----------------------------------------------------------------------------
// rcf_sum
// Second stage: adds the three weighted products of each channel.
// ----------------------------------------------------------------------------
module rcf_sum (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rcf_pkg::prod_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rcf_pkg::sum_type  out_data
);
   import rcf_pkg::*;

   logic    valid_ff;
   sum_type data_ff;
   sum_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in          = '0;
      data_in.alpha    = in_data.alpha;
      data_in.pop      = in_data.pop;
      data_in.pop_bits = in_data.pop_bits;
      for (int o = 0; o < NUM_CHAN; o++) begin
         data_in.sum[o] = in_data.prod[o][0] + in_data.prod[o][1] + in_data.prod[o][2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/rcf_scale.sv @@
// ----------------------------------------------------------------------------
// rcf_scale
// Third and fourth stages: divide by 1000 through a reciprocal product,
// then saturate and apply pop art.
// ----------------------------------------------------------------------------
module rcf_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rcf_pkg::sum_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rcf_pkg::pixel_type out_data
);
   import rcf_pkg::*;

   logic      mul_valid_ff;
   full_type  mul_ff;
   full_type  mul_in;
   logic      mul_ready;
   logic      out_valid_ff;
   pixel_type out_ff;
   pixel_type out_in;

   logic [NUM_CHAN-1:0][QUOT_W-1:0] quot;

   assign mul_ready = !out_valid_ff || out_ready;
   assign in_ready  = !mul_valid_ff || mul_ready;

   always_comb begin
      mul_in          = '0;
      mul_in.alpha    = in_data.alpha;
      mul_in.pop      = in_data.pop;
      mul_in.pop_bits = in_data.pop_bits;
      for (int o = 0; o < NUM_CHAN; o++) begin
         mul_in.full[o] = FULL_W'(in_data.sum[o]) * FULL_W'(RECIP_1000);
      end
   end

   always_comb begin
      out_in       = '0;
      out_in.alpha = mul_ff.alpha;
      for (int o = 0; o < NUM_CHAN; o++) begin
         quot[o] = mul_ff.full[o][RECIP_SHIFT +: QUOT_W];
         if (mul_ff.pop) begin
            out_in.color[o] = mul_ff.pop_bits[o] ? CHAN_MAX : '0;
         end else if (quot[o] > QUOT_W'(CHAN_MAX)) begin
            out_in.color[o] = CHAN_MAX;
         end else begin
            out_in.color[o] = quot[o][CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (mul_ready) begin
            out_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mul_ff <= mul_in;
      end
      if (mul_valid_ff && mul_ready) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rgb_color_filter. Pixels are streamed through the
// request channel under every filter mode, including the unused code, and
// each response is compared with a locally computed recolored pixel.
// Both channels stall at random, apart from a calm window with no stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import rcf_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 16;
   localparam int RAND_ITEMS  = 78;
   localparam int CALM_FROM   = 700;
   localparam int CALM_TO     = 1300;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } rgba_pixel_type;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              csr_write       = 1'b0;
   logic [MODE_W-1:0] csr_filter_mode = MODE_NONE;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic [CHAN_W-1:0] req_red_in      = '0;
   logic [CHAN_W-1:0] req_green_in    = '0;
   logic [CHAN_W-1:0] req_blue_in     = '0;
   logic [CHAN_W-1:0] req_alpha_in    = '0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   logic [CHAN_W-1:0] rsp_red_out;
   logic [CHAN_W-1:0] rsp_green_out;
   logic [CHAN_W-1:0] rsp_blue_out;
   logic [CHAN_W-1:0] rsp_alpha_out;

   rgba_pixel_type    pending_pixels[$];
   rgba_pixel_type    filtered_pixels[$];
   logic [MODE_W-1:0] active_mode = MODE_NONE;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   rgb_color_filter u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_filter_mode (csr_filter_mode),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_alpha_in    (req_alpha_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_alpha_out   (rsp_alpha_out)
   );

   always #1 clock = ~clock;

   function automatic logic [CHAN_W-1:0] clamp_chan(input int unsigned v);
      return (v > 255) ? CHAN_MAX : CHAN_W'(v);
   endfunction

   function automatic logic [CHAN_W-1:0] weigh_chan(input int unsigned r, g, b,
                                                    input int unsigned wr, wg, wb);
      return clamp_chan((r * wr + g * wg + b * wb) / 1000);
   endfunction

   function automatic rgba_pixel_type filter_pixel(input logic [MODE_W-1:0] mode,
                                                   input rgba_pixel_type px);
      int unsigned    r, g, b;
      rgba_pixel_type q;
      r = px.red;
      g = px.green;
      b = px.blue;
      q = px;
      case (mode)
         MODE_SEPIA: begin
            q.red   = weigh_chan(r, g, b, 393, 769, 189);
            q.green = weigh_chan(r, g, b, 349, 686, 168);
            q.blue  = weigh_chan(r, g, b, 272, 534, 131);
         end
         MODE_COOL: begin
            q.red  = CHAN_W'(r * 8 / 10);
            q.blue = clamp_chan(b * 12 / 10);
         end
         MODE_HEAT: begin
            q.red   = clamp_chan(r * 13 / 10);
            q.green = CHAN_W'(g * 9 / 10);
            q.blue  = CHAN_W'(b * 7 / 10);
         end
         MODE_GRAY: begin
            q.red   = weigh_chan(r, g, b, 299, 587, 114);
            q.green = q.red;
            q.blue  = q.red;
         end
         MODE_DARKEN: begin
            q.red   = CHAN_W'(r * 85 / 100);
            q.green = CHAN_W'(g * 85 / 100);
            q.blue  = CHAN_W'(b * 85 / 100);
         end
         MODE_POP: begin
            q.red   = (px.red > POP_THRESH) ? CHAN_MAX : '0;
            q.green = (px.green > POP_THRESH) ? CHAN_MAX : '0;
            q.blue  = (px.blue > POP_THRESH) ? CHAN_MAX : '0;
         end
         default: begin
         end
      endcase
      return q;
   endfunction

   function automatic logic take_gap();
      if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
         return 1'b0;
      end
      return $urandom_range(99) < 7;
   endfunction

   function automatic logic [CHAN_W-1:0] pick_chan();
      case ($urandom_range(7))
         0:       return '0;
         1:       return CHAN_MAX;
         2:       return POP_THRESH;
         3:       return POP_THRESH + 1'b1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin : drive_proc
      rgba_pixel_type px;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            filtered_pixels.push_back(filter_pixel(active_mode,
               {req_red_in, req_green_in, req_blue_in, req_alpha_in}));
         end
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0 && !take_gap()) begin
               px = pending_pixels.pop_front();
               req_valid    <= 1'b1;
               req_red_in   <= px.red;
               req_green_in <= px.green;
               req_blue_in  <= px.blue;
               req_alpha_in <= px.alpha;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : check_proc
      rgba_pixel_type want;
      rgba_pixel_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out};
            if (filtered_pixels.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response r=%0d g=%0d b=%0d a=%0d",
                        $time, got.red, got.green, got.blue, got.alpha);
            end else begin
               want = filtered_pixels.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                           $time, want.red, want.green, want.blue, want.alpha,
                           got.red, got.green, got.blue, got.alpha);
               end
            end
         end
         rsp_ready <= !take_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic load_mode(input logic [MODE_W-1:0] mode);
      @(posedge clock);
      csr_write       <= 1'b1;
      csr_filter_mode <= mode;
      @(posedge clock);
      csr_write   <= 1'b0;
      active_mode = mode;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || filtered_pixels.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   initial begin : stim_proc
      logic [MODE_W-1:0] sweep[8];
      rgba_pixel_type    corners[3];
      logic [MODE_W-1:0] mode;
      sweep = '{MODE_NONE, MODE_SEPIA, MODE_COOL, MODE_HEAT,
                MODE_GRAY, MODE_DARKEN, MODE_POP, MODE_SPARE};
      // dark, full white, and a mix on the pop threshold with heat red 90
      corners[0] = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0};
      corners[1] = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX, alpha: CHAN_MAX};
      corners[2] = '{red: 8'd90, green: POP_THRESH + 1'b1, blue: POP_THRESH, alpha: 8'hA5};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         if (p < 8) begin
            mode = sweep[p];
         end else if (p == 8) begin
            mode = MODE_NONE;
         end else begin
            mode = sweep[$urandom_range(7)];
         end
         // first phase runs on the reset value of the mode
         if (p > 0) begin
            load_mode(mode);
         end
         @(negedge clock);
         if (p < 8) begin
            for (int i = 0; i < 3; i++) begin
               pending_pixels.push_back(corners[i]);
            end
         end
         for (int i = 0; i < RAND_ITEMS; i++) begin
            pending_pixels.push_back('{red: pick_chan(), green: pick_chan(),
                                       blue: pick_chan(), alpha: CHAN_W'($urandom)});
         end
         drain();
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
